[rtl/mipc_pkg.sv]
// shared types, constants and format table for the mip chain size block
`timescale 1ns / 1ps
package mipc_pkg;

  localparam int MAX_MIP_LEVELS_DEF = 14;
  localparam int FORMAT_COUNT_DEF   = 3;

  localparam int FMT_W   = 2;
  localparam int DIM_W   = 16;
  localparam int REQ_W   = 8;
  localparam int LEVEL_W = 4;
  localparam int SIZE_W  = 34;
  localparam int AREA_W  = 2 * DIM_W;

  // formats that have a table entry
  localparam int TABLE_ENTRIES = 3;

  localparam logic [FMT_W-1:0] FMT_BYTE1   = 2'd0;
  localparam logic [FMT_W-1:0] FMT_BYTE2   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_BYTE4   = 2'd2;
  localparam logic [FMT_W-1:0] FMT_INVALID = 2'd3;

  typedef struct packed {
    logic [FMT_W-1:0] format;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [REQ_W-1:0] level_count;
  } desc_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [SIZE_W-1:0]  level_offset;
    logic [SIZE_W-1:0]  level_size;
    logic [SIZE_W-1:0]  mip_total;
    logic               last;
    logic               bad_format;
  } res_t;

  // log2 of bytes per pixel
  function automatic logic [1:0] pixel_shift(input logic [FMT_W-1:0] fmt);
    logic [1:0] s;
    unique case (fmt)
      FMT_BYTE1: s = 2'd0;
      FMT_BYTE2: s = 2'd1;
      FMT_BYTE4: s = 2'd2;
      default:   s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/mipc_area_mul.sv]
// shared pixel count multiplier: sizes floored at one past level 0, registered product
`timescale 1ns / 1ps
module mipc_area_mul
  import mipc_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DIM_W-1:0]  width,
  input  logic [DIM_W-1:0]  height,
  input  logic [IDX_W-1:0]  idx,
  output logic [AREA_W-1:0] prod
);

  logic [DIM_W-1:0] w_sh;
  logic [DIM_W-1:0] h_sh;
  logic [DIM_W-1:0] mw;
  logic [DIM_W-1:0] mh;

  // base level keeps the raw size, later levels floor at one pixel
  always_comb begin
    w_sh = width >> idx;
    h_sh = height >> idx;
    if (idx == '0) begin
      mw = width;
      mh = height;
    end else begin
      mw = (w_sh == '0) ? DIM_W'(1) : w_sh;
      mh = (h_sh == '0) ? DIM_W'(1) : h_sh;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= AREA_W'(mw) * AREA_W'(mh);
    end
  end

endmodule

[rtl/mip_chain_size_offsets_core.sv]
// top level: mip chain size and offset sequencer
`timescale 1ns / 1ps
// Takes one texture description per beat and returns one result beat per mip
// level, level 0 first, the last beat marked. A texture with n levels (the
// request clamped to 1..MAX_MIP_LEVELS) passes through ST_MUL and ST_EMIT
// once per level: one shared 16x16 multiplier registers each level's pixel
// count in ST_MUL and the offset adder loads the result register in ST_EMIT
// when the output is free. A bad format code gives a single flagged result
// beat. Further descriptions are stalled until the last result is loaded.
module mip_chain_size_offsets_core
  import mipc_pkg::*;
#(
  parameter int MAX_MIP_LEVELS = MAX_MIP_LEVELS_DEF,
  parameter int FORMAT_COUNT   = FORMAT_COUNT_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  desc_valid,
  output logic  desc_stall,
  input  desc_t desc,
  output logic  res_valid,
  input  logic  res_stall,
  output res_t  res
);

  localparam int CNT_W = $clog2(MAX_MIP_LEVELS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  levels;
  logic [DIM_W-1:0]  held_width;
  logic [DIM_W-1:0]  held_height;
  logic [1:0]        held_shift;
  logic              bad;
  logic [SIZE_W-1:0] total;
  logic [AREA_W-1:0] prod;

  logic              accept;
  logic              out_free;
  logic              fmt_bad;
  logic [CNT_W-1:0]  levels_next;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] total_next;
  logic              is_last;

  assign desc_stall = (state != ST_IDLE);
  assign accept     = desc_valid && !desc_stall;
  assign out_free   = !res_valid || !res_stall;

  // format check and level count clamp
  always_comb begin
    fmt_bad = ({2'b00, desc.format} >= 4'(FORMAT_COUNT)) ||
              ({2'b00, desc.format} >= 4'(TABLE_ENTRIES));
    if (desc.level_count == '0) begin
      levels_next = CNT_W'(1);
    end else if (desc.level_count > REQ_W'(MAX_MIP_LEVELS)) begin
      levels_next = CNT_W'(MAX_MIP_LEVELS);
    end else begin
      levels_next = CNT_W'(desc.level_count);
    end
  end

  mipc_area_mul #(
    .IDX_W (CNT_W)
  ) u_mul (
    .clk    (clk),
    .en     (state == ST_MUL),
    .width  (held_width),
    .height (held_height),
    .idx    (idx),
    .prod   (prod)
  );

  // level size, running total and end of chain
  always_comb begin
    size       = bad ? '0 : (SIZE_W'(prod) << held_shift);
    total_next = (idx == '0) ? '0 : total + size;
    is_last    = bad || ((idx + CNT_W'(1)) == levels);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= is_last ? ST_IDLE : ST_MUL;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // held texture description and level counter
  always_ff @(posedge clk) begin
    if (accept) begin
      held_width  <= desc.width;
      held_height <= desc.height;
      held_shift  <= pixel_shift(desc.format);
      levels      <= levels_next;
      bad         <= fmt_bad;
      idx         <= '0;
      total       <= '0;
    end else if (state == ST_EMIT && out_free) begin
      idx   <= idx + CNT_W'(1);
      total <= total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      res.level        <= LEVEL_W'(idx);
      res.level_offset <= (idx == '0) ? '0 : total;
      res.level_size   <= size;
      res.mip_total    <= total_next;
      res.last         <= is_last;
      res.bad_format   <= bad;
    end
  end

endmodule

[dv/tb_mip_chain_size_offsets_core.sv]
// testbench for the mip chain size and offset sequencer, self-checking
`timescale 1ns / 1ps
module tb_mip_chain_size_offsets_core;
  import mipc_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 2 * MAX_MIP_LEVELS_DEF + 12;
  localparam int RAND_PER_MIX = 120;
  localparam logic [63:0] SIZE_MASK = (64'd1 << SIZE_W) - 64'd1;

  // level layout predictor and store of pending level beats
  class mip_layout_board;
    res_t pending_levels[$];
    int   n_mismatch;
    int   n_textures;
    int   n_bad_fmt;
    int   n_levels_seen;

    task report(input string what);
      $display("mismatch: %s", what);
      n_mismatch++;
    endtask

    // work out every level beat that one texture description produces
    function void note_desc(input desc_t d);
      int unsigned  n_lvls;
      logic [1:0]   bpp_shift;
      logic [15:0]  mw;
      logic [15:0]  mh;
      logic [63:0]  lvl_bytes;
      logic [63:0]  area;
      res_t         r;
      n_textures++;
      r = '0;
      if (d.format >= FORMAT_COUNT_DEF) begin
        // unknown format: one flagged beat, all sizes zero
        r.last       = 1'b1;
        r.bad_format = 1'b1;
        n_bad_fmt++;
        pending_levels.push_back(r);
        return;
      end
      case (d.format)
        FMT_BYTE2: bpp_shift = 2'd1;
        FMT_BYTE4: bpp_shift = 2'd2;
        default:   bpp_shift = 2'd0;
      endcase
      n_lvls = d.level_count;
      if (n_lvls < 1) n_lvls = 1;
      if (n_lvls > MAX_MIP_LEVELS_DEF) n_lvls = MAX_MIP_LEVELS_DEF;
      area = '0;
      for (int i = 0; i < n_lvls; i++) begin
        mw = d.width >> i;
        mh = d.height >> i;
        // mip levels keep at least one pixel per side, the base does not
        if (i > 0) begin
          if (mw == 16'd0) mw = 16'd1;
          if (mh == 16'd0) mh = 16'd1;
        end
        lvl_bytes = (64'(mw) * 64'(mh)) << bpp_shift;
        r.level        = i[LEVEL_W-1:0];
        r.level_offset = (i == 0) ? '0 : area[SIZE_W-1:0];
        if (i > 0) area = (area + lvl_bytes) & SIZE_MASK;
        r.level_size   = lvl_bytes[SIZE_W-1:0];
        r.mip_total    = area[SIZE_W-1:0];
        r.last         = (i + 1 == n_lvls);
        r.bad_format   = 1'b0;
        pending_levels.push_back(r);
      end
    endfunction

    task cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
      if (got !== want)
        report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // compare one accepted level beat with the oldest prediction
    task check_res(input res_t got);
      res_t want;
      n_levels_seen++;
      if (pending_levels.size() == 0) begin
        report($sformatf("unexpected beat level %0d", got.level));
        return;
      end
      want = pending_levels.pop_front();
      cmp_field("level", 64'(got.level), 64'(want.level));
      cmp_field("level_offset", 64'(got.level_offset), 64'(want.level_offset));
      cmp_field("level_size", 64'(got.level_size), 64'(want.level_size));
      cmp_field("mip_total", 64'(got.mip_total), 64'(want.mip_total));
      cmp_field("last", 64'(got.last), 64'(want.last));
      cmp_field("bad_format", 64'(got.bad_format), 64'(want.bad_format));
    endtask

    function int pending();
      return pending_levels.size();
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  desc_valid;
  logic  desc_stall;
  desc_t desc;
  logic  res_valid;
  logic  res_stall;
  res_t  res;

  mip_layout_board sb;
  int send_idle_pct;
  int stall_pct;
  int hold_starts;
  int hold_seen;
  int hold_left;
  int quiet_cycles;

  mip_chain_size_offsets_core dut (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc       (desc),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_starts != hold_seen) begin
      hold_seen = hold_starts;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_res(res);
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (desc_valid && !desc_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one description, with random idle cycles ahead of it
  task send_desc(input desc_t d);
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        desc_valid <= 1'b0;
        @(posedge clk);
      end
    end
    desc       <= d;
    desc_valid <= 1'b1;
    @(posedge clk);
    while (desc_stall) @(posedge clk);
    sb.note_desc(d);
  endtask

  // stop offering and wait for every predicted beat to arrive
  task drain_levels();
    desc_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(3))
      0:       return DIM_W'($urandom);
      1:       return DIM_W'($urandom_range(64));
      2:       return DIM_W'(1) << $urandom_range(DIM_W - 1);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  function desc_t pick_desc();
    desc_t d;
    d.format      = ($urandom_range(9) == 0) ? FMT_INVALID : FMT_W'($urandom_range(2));
    d.width       = pick_dim();
    d.height      = pick_dim();
    d.level_count = ($urandom_range(9) < 7) ? REQ_W'($urandom_range(15))
                                            : REQ_W'($urandom);
    return d;
  endfunction

  function desc_t mk_desc(input logic [FMT_W-1:0] f, input logic [DIM_W-1:0] w,
                          input logic [DIM_W-1:0] h, input logic [REQ_W-1:0] lc);
    desc_t d;
    d.format      = f;
    d.width       = w;
    d.height      = h;
    d.level_count = lc;
    return d;
  endfunction

  int send_mix [4] = '{0, 66, 0, 36};
  int stall_mix[4] = '{0, 0, 66, 36};
  desc_t directed_q[$];

  initial begin
    sb            = new;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_starts   = 0;
    hold_seen     = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    rst        <= 1'b1;
    desc_valid <= 1'b0;
    desc       <= '0;
    res_stall  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, each format, clamping, zero sides, bad codes
    directed_q.push_back(mk_desc(FMT_BYTE1, 16'hFFFF, 16'hFFFF, 8'd14));
    directed_q.push_back(mk_desc(FMT_BYTE2, 16'hFFFF, 16'hFFFF, 8'd14));
    directed_q.push_back(mk_desc(FMT_BYTE4, 16'hFFFF, 16'hFFFF, 8'd255));
    directed_q.push_back(mk_desc(FMT_BYTE4, 16'hFFFF, 16'hFFFF, 8'd15));
    directed_q.push_back(mk_desc(FMT_INVALID, 16'hFFFF, 16'hFFFF, 8'd255));
    directed_q.push_back(mk_desc(FMT_INVALID, 16'd0, 16'd0, 8'd0));
    directed_q.push_back(mk_desc(FMT_BYTE1, 16'd16, 16'd16, 8'd0));
    directed_q.push_back(mk_desc(FMT_BYTE2, 16'd16, 16'd16, 8'd1));
    directed_q.push_back(mk_desc(FMT_BYTE4, 16'd0, 16'd0, 8'd14));
    directed_q.push_back(mk_desc(FMT_BYTE1, 16'd0, 16'hFFFF, 8'd14));
    directed_q.push_back(mk_desc(FMT_BYTE2, 16'hFFFF, 16'd0, 8'd6));
    directed_q.push_back(mk_desc(FMT_BYTE4, 16'd1, 16'd1, 8'd14));
    directed_q.push_back(mk_desc(FMT_BYTE1, 16'hFFFF, 16'd1, 8'd16));
    directed_q.push_back(mk_desc(FMT_BYTE4, 16'h8000, 16'h5555, 8'd13));
    directed_q.push_back(mk_desc(FMT_BYTE2, 16'h2AAA, 16'h8001, 8'd128));
    directed_q.push_back(mk_desc(FMT_INVALID, 16'h1234, 16'h00FF, 8'd3));
    foreach (directed_q[k]) send_desc(directed_q[k]);
    drain_levels();

    // long receiver hold-off while descriptions keep coming
    hold_starts++;
    repeat (20) send_desc(pick_desc());
    drain_levels();

    // random traffic under each idle and stall mix
    for (int m = 0; m < 4; m++) begin
      send_idle_pct = send_mix[m];
      stall_pct     = stall_mix[m];
      repeat (RAND_PER_MIX) send_desc(pick_desc());
      drain_levels();
    end

    stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d level beats never arrived", sb.pending()));

    $display("covered %0d texture descriptions (%0d with a bad format), %0d level beats",
             sb.n_textures, sb.n_bad_fmt, sb.n_levels_seen);
    $display("under four idle/stall mixes plus a %0d-cycle receiver hold-off, %0d mismatches",
             LONG_HOLD, sb.n_mismatch);
    if (sb.n_mismatch == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
